>>> rtl/rtcl_pkg.sv
// shared types, register select codes and divider constants for the cartridge rtc block
// no dependencies; used by the split unit, the top level and the testbench
package rtcl_pkg;

	// transfer kinds
	localparam logic KIND_LATCH = 1'b0;
	localparam logic KIND_REG   = 1'b1;

	// clock register selects
	localparam logic [3:0] SEL_SECONDS  = 4'd8;
	localparam logic [3:0] SEL_MINUTES  = 4'd9;
	localparam logic [3:0] SEL_HOURS    = 4'd10;
	localparam logic [3:0] SEL_DAYS_LOW = 4'd11;
	localparam logic [3:0] SEL_FLAGS    = 4'd12;

	// flag register bit positions
	localparam int unsigned STOP_BIT  = 6;
	localparam int unsigned CARRY_BIT = 7;

	localparam logic [31:0] SEC_PER_MIN  = 32'd60;
	localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
	localparam logic [31:0] SEC_PER_DAY  = 32'd86400;

	// reciprocals: floor(x*m >> k) == floor(x/d) over the stated operand range
	localparam logic [31:0] RECIP_60_X32 = 32'h8888_8889;    // x < 2^32, k = 37
	localparam logic [27:0] RECIP_60_X27 = 28'd143165577;    // x < 2^27, k = 33
	localparam logic [21:0] RECIP_24_X21 = 22'd2796203;      // x < 2^21, k = 26

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [3:0]  select;
		logic [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic [7:0] shown_seconds;
		logic [7:0] shown_minutes;
		logic [7:0] shown_hours;
		logic [7:0] shown_days_low;
		logic [7:0] shown_flags;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [31:0] now_seconds;
		logic [31:0] epoch;
	} split_req_t;

	typedef struct packed {
		logic        valid;
		logic [5:0]  seconds;
		logic [5:0]  minutes;
		logic [4:0]  hours;
		logic [15:0] days;
	} split_res_t;

endpackage

>>> rtl/rtcl_if.sv
// valid/ready channel interfaces for bus writes in and visible register bytes out
// no dependencies
interface rtcl_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data;
	logic [3:0]  select;
	logic [31:0] now_seconds;

	modport source (output valid, kind, data, select, now_seconds, input ready);
	modport sink   (input valid, kind, data, select, now_seconds, output ready);
endinterface

interface rtcl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] shown_seconds;
	logic [7:0] shown_minutes;
	logic [7:0] shown_hours;
	logic [7:0] shown_days_low;
	logic [7:0] shown_flags;

	modport source (output valid, shown_seconds, shown_minutes, shown_hours, shown_days_low,
		shown_flags, input ready);
	modport sink   (input valid, shown_seconds, shown_minutes, shown_hours, shown_days_low,
		shown_flags, output ready);
endinterface

>>> rtl/cartridge_rtc_latch_and_set_core.sv
// a register write or a latch that splits nothing goes from transfer to result through the
// input register, then the state and result register; one such item per cycle while no split
// runs and the result slot is free; a latch that splits running time holds off the next item
// until the subtract and three chained reciprocal multiplies of the split unit are through
// asynchronous reset clears all clock state, the visible registers and the epoch to zero
// top level; depends on rtcl_pkg, rtcl_if and rtcl_split
module cartridge_rtc_latch_and_set_core (
	input  logic          clk,
	input  logic          arst_n,
	rtcl_in_if.sink       item,
	rtcl_out_if.source    result
);

	// input register
	rtcl_pkg::in_item_t item_s1;
	logic               item_valid_s1;

	// clock state
	logic               last_latch_q;
	logic [31:0]        epoch_q;
	logic [5:0]         sec_q;
	logic [5:0]         min_q;
	logic [4:0]         hr_q;
	logic [15:0]        days_q;
	logic [7:0]         flags_q;
	rtcl_pkg::result_t  vis_q;      // visible registers, also the result payload
	logic               out_valid_q;
	logic               busy_q;     // split in flight

	logic               last_latch_n;
	logic [31:0]        epoch_n;
	logic [5:0]         sec_n;
	logic [5:0]         min_n;
	logic [4:0]         hr_n;
	logic [15:0]        days_n;
	logic [7:0]         flags_n;
	rtcl_pkg::result_t  vis_n;
	logic [31:0]        total;

	logic               is_latch;
	logic               rising;
	logic               needs_split;
	logic               out_free;
	logic               fast_done;
	logic               complete;

	rtcl_pkg::split_req_t split_req;
	rtcl_pkg::split_res_t split_res;

	// byte reduced modulo 60 by restoring steps of 240, 120, 60
	function automatic logic [5:0] mod_60(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (r >= 8'd240) r = r - 8'd240;
		if (r >= 8'd120) r = r - 8'd120;
		if (r >= 8'd60)  r = r - 8'd60;
		return r[5:0];
	endfunction

	// byte reduced modulo 24 by restoring steps of 192, 96, 48, 24
	function automatic logic [4:0] mod_24(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (r >= 8'd192) r = r - 8'd192;
		if (r >= 8'd96)  r = r - 8'd96;
		if (r >= 8'd48)  r = r - 8'd48;
		if (r >= 8'd24)  r = r - 8'd24;
		return r[4:0];
	endfunction

	// visible bytes from the counts; flags byte carries day bit 8 in bit 0
	function automatic rtcl_pkg::result_t refresh(input logic [5:0] s, input logic [5:0] m,
		input logic [4:0] h, input logic [15:0] d, input logic [7:0] f);
		rtcl_pkg::result_t v;
		v.shown_seconds  = {2'b00, s};
		v.shown_minutes  = {2'b00, m};
		v.shown_hours    = {3'b000, h};
		v.shown_days_low = d[7:0];
		v.shown_flags    = {f[7:1], d[8]};
		return v;
	endfunction

	// handshake and sequencing
	always_comb begin
		is_latch    = (item_s1.kind == rtcl_pkg::KIND_LATCH);
		rising      = is_latch && item_s1.data[0] && !last_latch_q;
		needs_split = item_valid_s1 && rising && !flags_q[rtcl_pkg::STOP_BIT];
		out_free    = !out_valid_q || result.ready;
		// anything but a running-clock latch finishes once no split runs and the result slot is free
		fast_done   = item_valid_s1 && !busy_q && !needs_split && out_free;
		// the result slot is free at start and nothing else loads it while busy
		split_req.start       = needs_split && !busy_q && out_free;
		split_req.now_seconds = item_s1.now_seconds;
		split_req.epoch       = epoch_q;
		complete    = fast_done || split_res.valid;
		item.ready  = !item_valid_s1 || complete;
	end

	rtcl_split u_split (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (split_req),
		.res    (split_res)
	);

	// next state of the clock
	always_comb begin
		last_latch_n = last_latch_q;
		epoch_n      = epoch_q;
		sec_n        = sec_q;
		min_n        = min_q;
		hr_n         = hr_q;
		days_n       = days_q;
		flags_n      = flags_q;
		vis_n        = vis_q;
		total        = 32'd0;

		if (split_res.valid) begin
			// split done: take the new counts, carry once days pass 511
			sec_n  = split_res.seconds;
			min_n  = split_res.minutes;
			hr_n   = split_res.hours;
			days_n = split_res.days;
			if (|split_res.days[15:9]) begin
				flags_n[rtcl_pkg::CARRY_BIT] = 1'b1;
			end
			vis_n  = refresh(sec_n, min_n, hr_n, days_n, flags_n);
		end else if (fast_done) begin
			if (is_latch) begin
				last_latch_n = item_s1.data[0];
				// stopped clock: refresh from held counts
				if (rising) begin
					vis_n = refresh(sec_q, min_q, hr_q, days_q, flags_q);
				end
			end else begin
				unique case (item_s1.select)
					rtcl_pkg::SEL_SECONDS: begin
						vis_n.shown_seconds = item_s1.data;
						sec_n = mod_60(item_s1.data);
					end
					rtcl_pkg::SEL_MINUTES: begin
						vis_n.shown_minutes = item_s1.data;
						min_n = mod_60(item_s1.data);
					end
					rtcl_pkg::SEL_HOURS: begin
						vis_n.shown_hours = item_s1.data;
						hr_n = mod_24(item_s1.data);
					end
					rtcl_pkg::SEL_DAYS_LOW: begin
						// days above bit 8 are dropped
						vis_n.shown_days_low = item_s1.data;
						days_n = {7'd0, days_q[8], item_s1.data};
					end
					rtcl_pkg::SEL_FLAGS: begin
						vis_n.shown_flags = item_s1.data;
						flags_n = item_s1.data;
						days_n = {7'd0, item_s1.data[0], days_q[7:0]};
					end
					default: begin
						// no field changes, epoch still recomputed
					end
				endcase
				// epoch so that running time equals the new counts, modulo 2^32
				total = 32'(sec_n) + 32'(min_n) * rtcl_pkg::SEC_PER_MIN
					+ 32'(hr_n) * rtcl_pkg::SEC_PER_HOUR + 32'(days_n) * rtcl_pkg::SEC_PER_DAY;
				epoch_n = item_s1.now_seconds - total;
			end
		end

		// the rising latch bit is recorded when its split starts
		if (split_req.start) begin
			last_latch_n = 1'b1;
		end
	end

	// control and clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			busy_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			last_latch_q  <= 1'b0;
			epoch_q       <= 32'd0;
			sec_q         <= 6'd0;
			min_q         <= 6'd0;
			hr_q          <= 5'd0;
			days_q        <= 16'd0;
			flags_q       <= 8'd0;
			vis_q         <= '0;
		end else begin
			if (item.ready) begin
				item_valid_s1 <= item.valid;
			end
			if (split_req.start) begin
				busy_q <= 1'b1;
			end else if (split_res.valid) begin
				busy_q <= 1'b0;
			end
			if (complete) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			last_latch_q <= last_latch_n;
			epoch_q      <= epoch_n;
			sec_q        <= sec_n;
			min_q        <= min_n;
			hr_q         <= hr_n;
			days_q       <= days_n;
			flags_q      <= flags_n;
			vis_q        <= vis_n;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= '{kind: item.kind, data: item.data, select: item.select,
				now_seconds: item.now_seconds};
		end
	end

	// result channel
	always_comb begin
		result.valid          = out_valid_q;
		result.shown_seconds  = vis_q.shown_seconds;
		result.shown_minutes  = vis_q.shown_minutes;
		result.shown_hours    = vis_q.shown_hours;
		result.shown_days_low = vis_q.shown_days_low;
		result.shown_flags    = vis_q.shown_flags;
	end

	// split results only arrive for a split that was started
	a_split_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		split_res.valid |-> busy_q)
		else $error("split result without a split in flight");

	// no second split is started while one is running
	a_single_split: assert property (@(posedge clk) disable iff (!arst_n)
		split_req.start |-> !busy_q)
		else $error("split started while busy");

	// a finished split never meets an untaken result
	a_slot_free_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		split_res.valid |-> !out_valid_q)
		else $error("split finished with result slot occupied");

	// a fresh result only follows a completed item
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(complete))
		else $error("result appeared without a completed item");

	// clock state does not move while a split is running
	a_state_held_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !split_res.valid) |=> ($stable(epoch_q) && $stable(days_q)))
		else $error("clock state changed during a split");

endmodule

>>> rtl/rtcl_split.sv
// pipelined split of running time into seconds, minutes, hours and days
// constant division by reciprocal multiplication; depends on rtcl_pkg
module rtcl_split (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rtcl_pkg::split_req_t    req,
	output rtcl_pkg::split_res_t    res
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [31:0] t_s1;
	logic [63:0] p1_s2;
	logic [7:0]  t_lo_s2;
	logic [53:0] p2_s3;
	logic [7:0]  q1_lo_s3;
	logic [5:0]  sec_s3;
	logic [41:0] p3_s4;
	logic [7:0]  q2_lo_s4;
	logic [5:0]  sec_s4;
	logic [5:0]  min_s4;

	logic [26:0] q1;
	logic [20:0] q2;
	logic [15:0] q3;
	logic [7:0]  q1_by60;
	logic [7:0]  q2_by60;
	logic [7:0]  q3_by24;
	logic [7:0]  sec_full;
	logic [7:0]  min_full;
	logic [7:0]  hr_full;

	always_comb begin
		// total seconds / 60
		q1       = p1_s2[63:37];
		q1_by60  = q1[7:0] * 8'd60;
		sec_full = t_lo_s2 - q1_by60;
		// total minutes / 60
		q2       = p2_s3[53:33];
		q2_by60  = q2[7:0] * 8'd60;
		min_full = q1_lo_s3 - q2_by60;
		// total hours / 24
		q3       = p3_s4[41:26];
		q3_by24  = q3[7:0] * 8'd24;
		hr_full  = q2_lo_s4 - q3_by24;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= req.start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		t_s1     <= req.now_seconds - req.epoch;
		p1_s2    <= 64'(t_s1) * 64'(rtcl_pkg::RECIP_60_X32);
		t_lo_s2  <= t_s1[7:0];
		p2_s3    <= 54'(q1) * 54'(rtcl_pkg::RECIP_60_X27);
		q1_lo_s3 <= q1[7:0];
		sec_s3   <= sec_full[5:0];
		p3_s4    <= 42'(q2) * 42'(rtcl_pkg::RECIP_24_X21);
		q2_lo_s4 <= q2[7:0];
		sec_s4   <= sec_s3;
		min_s4   <= min_full[5:0];
	end

	always_comb begin
		res.valid   = valid_s4;
		res.seconds = sec_s4;
		res.minutes = min_s4;
		res.hours   = hr_full[4:0];
		res.days    = q3;
	end

endmodule

>>> tb/testbench.sv
// testbench for the cartridge rtc latch and set core: bus writes in, visible register bytes out
// predicts every transfer in step with the block and compares field by field
// depends on rtcl_pkg, rtcl_if and cartridge_rtc_latch_and_set_core
`timescale 1ns / 100ps

module testbench;

	// cycles with no transfer on either side before the run is abandoned
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned RANDOM_WRITES = 900;
	localparam int unsigned MAX_REPORTS = 10;

	logic clk;
	logic arst_n;

	rtcl_in_if  item_ch ();
	rtcl_out_if result_ch ();

	cartridge_rtc_latch_and_set_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// bus writes waiting to be offered, and visible register sets still owed by the block
	rtcl_pkg::in_item_t bus_write_q [$];
	rtcl_pkg::result_t  visible_expected_q [$];

	// predicted clock state, starting from zero as the one reset leaves it
	logic              rtc_last_latch = 1'b0;
	logic [31:0]       rtc_epoch = '0;
	logic [5:0]        rtc_seconds = '0;
	logic [5:0]        rtc_minutes = '0;
	logic [4:0]        rtc_hours = '0;
	logic [15:0]       rtc_days = '0;
	logic [7:0]        rtc_flags = '0;
	rtcl_pkg::result_t rtc_visible = '0;

	rtcl_pkg::in_item_t offered;
	logic [31:0] wall_seconds = '0;
	int unsigned inputs_accepted = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;
	int unsigned hold_cycles = 0;
	logic        hold_done = 1'b0;

	// bring the predicted state up to date with one accepted bus write
	task automatic apply_bus_write(input rtcl_pkg::in_item_t w);
		logic [31:0] running;
		logic [31:0] total;
		if (w.kind == rtcl_pkg::KIND_LATCH) begin
			if (w.data[0] && !rtc_last_latch) begin
				// a stopped clock keeps its held counts, the visible copy still refreshes
				if (!rtc_flags[rtcl_pkg::STOP_BIT]) begin
					running = w.now_seconds - rtc_epoch;
					rtc_seconds = 6'(running % rtcl_pkg::SEC_PER_MIN);
					rtc_minutes = 6'((running / rtcl_pkg::SEC_PER_MIN) % rtcl_pkg::SEC_PER_MIN);
					rtc_hours = 5'((running / rtcl_pkg::SEC_PER_HOUR) % 32'd24);
					rtc_days = 16'(running / rtcl_pkg::SEC_PER_DAY);
					if (rtc_days >= 16'd512)
						rtc_flags[rtcl_pkg::CARRY_BIT] = 1'b1;
				end
				rtc_visible.shown_seconds = {2'b00, rtc_seconds};
				rtc_visible.shown_minutes = {2'b00, rtc_minutes};
				rtc_visible.shown_hours = {3'b000, rtc_hours};
				rtc_visible.shown_days_low = rtc_days[7:0];
				rtc_visible.shown_flags = {rtc_flags[7:1], rtc_days[8]};
			end
			rtc_last_latch = w.data[0];
		end else begin
			case (w.select)
				rtcl_pkg::SEL_SECONDS: begin
					rtc_visible.shown_seconds = w.data;
					rtc_seconds = 6'(w.data % 8'd60);
				end
				rtcl_pkg::SEL_MINUTES: begin
					rtc_visible.shown_minutes = w.data;
					rtc_minutes = 6'(w.data % 8'd60);
				end
				rtcl_pkg::SEL_HOURS: begin
					rtc_visible.shown_hours = w.data;
					rtc_hours = 5'(w.data % 8'd24);
				end
				rtcl_pkg::SEL_DAYS_LOW: begin
					rtc_visible.shown_days_low = w.data;
					rtc_days = {7'd0, rtc_days[8], w.data};
				end
				rtcl_pkg::SEL_FLAGS: begin
					// day bits above bit 8 are lost here
					rtc_visible.shown_flags = w.data;
					rtc_flags = w.data;
					rtc_days = {7'd0, w.data[0], rtc_days[7:0]};
				end
				default: ;
			endcase
			// every register write moves the epoch, whatever the select
			total = 32'(rtc_seconds) + 32'(rtc_minutes) * rtcl_pkg::SEC_PER_MIN
				+ 32'(rtc_hours) * rtcl_pkg::SEC_PER_HOUR
				+ 32'(rtc_days) * rtcl_pkg::SEC_PER_DAY;
			rtc_epoch = w.now_seconds - total;
		end
		visible_expected_q.push_back(rtc_visible);
	endtask

	task automatic queue_write(input logic kind, input logic [7:0] data,
			input logic [3:0] sel, input logic [31:0] now);
		rtcl_pkg::in_item_t w;
		w.kind = kind;
		w.data = data;
		w.select = sel;
		w.now_seconds = now;
		bus_write_q.push_back(w);
	endtask

	// free-running seconds mostly creep forward, now and then leap by days or land anywhere
	task automatic advance_wall();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 85)
			wall_seconds = wall_seconds + $urandom_range(0, 120);
		else if (pick < 97)
			wall_seconds = wall_seconds + $urandom_range(0, 700 * 86400);
		else
			wall_seconds = $urandom();
	endtask

	// latch pair: low then high on bit 0, upper data bits random
	task automatic queue_latch_pair();
		advance_wall();
		queue_write(rtcl_pkg::KIND_LATCH, {7'($urandom()), 1'b0}, 4'($urandom()), wall_seconds);
		advance_wall();
		queue_write(rtcl_pkg::KIND_LATCH, {7'($urandom()), 1'b1}, 4'($urandom()), wall_seconds);
	endtask

	task automatic queue_stimulus();
		int unsigned pick;
		logic [7:0]  value;
		logic [3:0]  sel;

		// directed: reset state latch, held and falling latch bit, full wrap of now
		queue_write(rtcl_pkg::KIND_LATCH, 8'h00, 4'h0, 32'd0);
		queue_write(rtcl_pkg::KIND_LATCH, 8'h01, 4'h0, 32'd0);
		queue_write(rtcl_pkg::KIND_LATCH, 8'hff, 4'hf, 32'hffff_ffff);
		queue_write(rtcl_pkg::KIND_LATCH, 8'hfe, 4'h8, 32'd123);
		queue_write(rtcl_pkg::KIND_LATCH, 8'h01, 4'h0, 32'hffff_ffff);
		// each field written, seconds and hours with an out of range byte, then the flags with day bit 8
		queue_write(rtcl_pkg::KIND_REG, 8'hff, rtcl_pkg::SEL_SECONDS, 32'd1000);
		queue_write(rtcl_pkg::KIND_REG, 8'd59, rtcl_pkg::SEL_MINUTES, 32'd1000);
		queue_write(rtcl_pkg::KIND_REG, 8'hff, rtcl_pkg::SEL_HOURS, 32'd1000);
		queue_write(rtcl_pkg::KIND_REG, 8'hff, rtcl_pkg::SEL_DAYS_LOW, 32'd1000);
		queue_write(rtcl_pkg::KIND_REG, 8'h01, rtcl_pkg::SEL_FLAGS, 32'd1000);
		// selects outside the clock registers still move the epoch
		queue_write(rtcl_pkg::KIND_REG, 8'haa, 4'h0, 32'd5000);
		queue_write(rtcl_pkg::KIND_REG, 8'h55, 4'hf, 32'h8000_0000);
		queue_write(rtcl_pkg::KIND_REG, 8'h00, 4'h7, 32'd0);
		queue_write(rtcl_pkg::KIND_REG, 8'hff, 4'hd, 32'hffff_ffff);
		// day count well past 511 raises carry
		queue_write(rtcl_pkg::KIND_LATCH, 8'h00, 4'h0, 32'd0);
		queue_write(rtcl_pkg::KIND_LATCH, 8'h01, 4'h0, 32'h8000_0000 + 32'd900 * 32'd86400);
		// stopped clock: latch shows held counts
		queue_write(rtcl_pkg::KIND_REG, 8'h41, rtcl_pkg::SEL_FLAGS, 32'd7777);
		queue_write(rtcl_pkg::KIND_LATCH, 8'h00, 4'h0, 32'd8000);
		queue_write(rtcl_pkg::KIND_LATCH, 8'h01, 4'h0, 32'd99999);
		// running again, carry cleared by the write
		queue_write(rtcl_pkg::KIND_REG, 8'h80, rtcl_pkg::SEL_FLAGS, 32'd100);
		queue_write(rtcl_pkg::KIND_REG, 8'h00, rtcl_pkg::SEL_FLAGS, 32'd200);
		queue_write(rtcl_pkg::KIND_LATCH, 8'h00, 4'h0, 32'd300);
		queue_write(rtcl_pkg::KIND_LATCH, 8'h01, 4'h0, 32'd86400 * 32'd3 + 32'd3661);

		// random: mostly sensible clock traffic, some stop flag use, the rest noise
		while (bus_write_q.size() < 25 + RANDOM_WRITES) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				queue_latch_pair();
			end else if (pick < 72) begin
				sel = 4'($urandom_range(rtcl_pkg::SEL_SECONDS, rtcl_pkg::SEL_FLAGS));
				value = 8'($urandom());
				if ($urandom_range(3) != 0) begin
					case (sel)
						rtcl_pkg::SEL_SECONDS, rtcl_pkg::SEL_MINUTES:
							value = 8'($urandom_range(59));
						rtcl_pkg::SEL_HOURS: value = 8'($urandom_range(23));
						rtcl_pkg::SEL_FLAGS: value = value & 8'hbf;
						default: ;
					endcase
				end
				advance_wall();
				queue_write(rtcl_pkg::KIND_REG, value, sel, wall_seconds);
			end else if (pick < 82) begin
				advance_wall();
				queue_write(rtcl_pkg::KIND_REG, 8'($urandom()) | 8'h40, rtcl_pkg::SEL_FLAGS,
					wall_seconds);
				queue_latch_pair();
				advance_wall();
				queue_write(rtcl_pkg::KIND_REG, 8'($urandom()) & 8'hbf, rtcl_pkg::SEL_FLAGS,
					wall_seconds);
				queue_latch_pair();
			end else begin
				queue_write(1'($urandom()), 8'($urandom()), 4'($urandom()), $urandom());
			end
		end
	endtask

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// sender: offers the next bus write whenever the channel is free, idling now and then
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				apply_bus_write(offered);
				inputs_accepted <= inputs_accepted + 1;
			end
			if (!item_ch.valid || item_ch.ready) begin
				// a calm stretch in the middle of the run with no sender gaps
				if (bus_write_q.size() != 0 && ((inputs_accepted >= 450 && inputs_accepted < 600)
						|| $urandom_range(99) >= 18)) begin
					offered = bus_write_q.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.kind <= offered.kind;
					item_ch.data <= offered.data;
					item_ch.select <= offered.select;
					item_ch.now_seconds <= offered.now_seconds;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each transfer against the oldest expectation and throttles ready
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen <= results_seen + 1;
				if (visible_expected_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < MAX_REPORTS)
						$display("unexpected result: %h %h %h %h %h",
							result_ch.shown_seconds, result_ch.shown_minutes,
							result_ch.shown_hours, result_ch.shown_days_low,
							result_ch.shown_flags);
				end else begin
					if (visible_expected_q[0].shown_seconds !== result_ch.shown_seconds
							|| visible_expected_q[0].shown_minutes !== result_ch.shown_minutes
							|| visible_expected_q[0].shown_hours !== result_ch.shown_hours
							|| visible_expected_q[0].shown_days_low !== result_ch.shown_days_low
							|| visible_expected_q[0].shown_flags !== result_ch.shown_flags) begin
						mismatches <= mismatches + 1;
						if (mismatches < MAX_REPORTS)
							$display("result %0d: expected s %h m %h h %h d %h f %h,",
								results_seen, visible_expected_q[0].shown_seconds,
								visible_expected_q[0].shown_minutes,
								visible_expected_q[0].shown_hours,
								visible_expected_q[0].shown_days_low,
								visible_expected_q[0].shown_flags,
								" got s %h m %h h %h d %h f %h",
								result_ch.shown_seconds, result_ch.shown_minutes,
								result_ch.shown_hours, result_ch.shown_days_low,
								result_ch.shown_flags);
					end
					void'(visible_expected_q.pop_front());
				end
			end
			// one long hold-off so the block backs up and stalls its input
			if (hold_cycles != 0) begin
				hold_cycles <= hold_cycles - 1;
				result_ch.ready <= 1'b0;
			end else if (!hold_done && inputs_accepted >= 300) begin
				hold_done <= 1'b1;
				hold_cycles <= 150;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= (results_seen >= 450 && results_seen < 600)
					|| $urandom_range(99) >= 18;
			end
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	initial begin
		// all inputs known from time zero
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = rtcl_pkg::KIND_LATCH;
		item_ch.data = '0;
		item_ch.select = '0;
		item_ch.now_seconds = '0;
		result_ch.ready = 1'b0;
		queue_stimulus();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every bus write taken, then every result back, then a short drain
		while (bus_write_q.size() != 0 || item_ch.valid)
			@(posedge clk);
		while (visible_expected_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (mismatches == 0 && visible_expected_q.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
